@@ rtl/ssd_pkg.sv @@
// Shared types, register indexes and helpers for the sampled sensor detection block.
// Holds the payload structs, configuration struct and mode/status codes.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  // Default series step counter width.
  localparam int unsigned STEP_BITS_DEF = 16;

  // Field widths fixed by the interface.
  localparam int unsigned CONC_W   = 32;
  localparam int unsigned CFG16_W  = 16;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned TIME_W   = 18;
  localparam int unsigned REGIDX_W = 3;
  localparam int unsigned CFGDAT_W = 32;

  // Sampling mode codes.
  typedef enum logic [1:0] {
    MODE_INST = 2'd0,
    MODE_COMP = 2'd1,
    MODE_FILT = 2'd2,
    MODE_BAD  = 2'd3
  } ssd_mode_t;

  // Result status codes.
  localparam logic [1:0] STAT_NONE = 2'd0;
  localparam logic [1:0] STAT_HIT  = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  // Configuration register indexes.
  localparam logic [REGIDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_START  = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_PERIOD = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_DELAY  = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_LIMIT  = 3'd4;
  localparam logic [REGIDX_W-1:0] REG_VOLUME = 3'd5;

  // Scale used by composite mode: 1.0 in Q8.8.
  localparam logic [CFG16_W-1:0] SCALE_ONE = 16'd256;

  // Input item.
  typedef struct packed {
    logic [CONC_W-1:0] concentration;
    logic              last_sample;
  } ssd_in_t;

  // Result item.
  typedef struct packed {
    logic [1:0]        status;
    logic [TIME_W-1:0] detect_time;
  } ssd_out_t;

  // Configuration register set.
  typedef struct packed {
    ssd_mode_t          sample_mode;
    logic [CFG16_W-1:0] start_step;
    logic [CFG16_W-1:0] sample_period;
    logic [CFG16_W-1:0] lab_delay;
    logic [CONC_W-1:0]  detect_limit;
    logic [CFG16_W-1:0] sample_volume;
  } ssd_cfg_t;

  // A zero start or period behaves as one.
  function automatic logic [CFG16_W-1:0] eff_nonzero(input logic [CFG16_W-1:0] v);
    eff_nonzero = (v == '0) ? CFG16_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ssd_hit_cmp.sv @@
// Window threshold compare for the sampled sensor detection block.
// Tests sum * scale > limit * period * 256 exactly; depends on ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssd_hit_cmp
  import ssd_pkg::*;
(
  input  wire ssd_cfg_t         cfg,
  input  wire logic [SUM_W-1:0] sum,
  output logic                  hit
);

  localparam int unsigned PROD_W = SUM_W + CFG16_W;
  localparam int unsigned RHS_W  = CONC_W + CFG16_W;

  logic [CFG16_W-1:0] scale;
  logic [CFG16_W-1:0] period_eff;
  logic [PROD_W-1:0]  lhs;
  logic [RHS_W-1:0]   rhs_base;
  logic [PROD_W-1:0]  rhs;

  // Filtered mode scales by the sample volume; composite uses 1.0.
  assign scale      = (cfg.sample_mode == MODE_FILT) ? cfg.sample_volume : SCALE_ONE;
  assign period_eff = eff_nonzero(cfg.sample_period);

  // Both products fit in 64 bits, so the compare is exact.
  assign lhs      = PROD_W'(sum) * PROD_W'(scale);
  assign rhs_base = RHS_W'(cfg.detect_limit) * RHS_W'(period_eff);
  assign rhs      = PROD_W'(rhs_base) << 8;

  assign hit = (lhs > rhs);

endmodule

`default_nettype wire

@@ rtl/sampled_sensor_detection.sv @@
// Top level of the sampled sensor detection block.
// Depends on ssd_pkg and ssd_hit_cmp.
//
// Usage: one concentration sample enters per time step on the input channel
// (in_valid / in_stall / in_data); the sample flagged last_sample closes the
// series. Each series produces exactly one result on the output channel
// (out_valid / out_stall / out_data): a detection time, no detection, or an
// invalid mode status. Configuration registers are written through
// cfg_valid / cfg_index / cfg_data; cfg_ready is always high.
// Throughput: one sample per clock while the result channel does not stall.
// A sample passes from the input register through one evaluation stage
// (add, two multiplies and a compare) to the result register, from which
// its result, if any, is transferred.
// Reset clears the series state and loads the register defaults; there is
// no clearing pass, so the block takes samples right after reset.
// When the receiver stalls, the result is held in the result register; if
// the input register is empty, it takes one more sample, then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module sampled_sensor_detection
  import ssd_pkg::*;
#(
  parameter int unsigned STEP_BITS = STEP_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Sample channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ssd_in_t             in_data,
  // Result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ssd_out_t                 out_data,
  // Configuration channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [REGIDX_W-1:0] cfg_index,
  input  wire logic [CFGDAT_W-1:0] cfg_data
);

  // Check step width: wide enough for both the counter and a 16-bit start.
  localparam int unsigned CNT_W = (STEP_BITS > CFG16_W) ? STEP_BITS : CFG16_W;
  localparam int unsigned NCS_W = CNT_W + 1;
  localparam int unsigned DT_W  = NCS_W + 1;

  // Configuration registers.
  ssd_cfg_t cfg_r;

  // Input register.
  logic    item_v_r;
  ssd_in_t item_r;

  // Series state.
  logic [STEP_BITS-1:0] step_count_r, step_count_nxt;
  logic [SUM_W-1:0]     window_sum_r, window_sum_nxt;
  logic [NCS_W-1:0]     ncs_r, ncs_nxt;
  logic                 reported_r, reported_nxt;

  // Result register.
  logic     out_v_r;
  ssd_out_t out_r, out_nxt;

  // Evaluation signals.
  logic                 fire;
  logic                 out_free;
  logic [CFG16_W-1:0]   start_eff, period_eff;
  logic [NCS_W-1:0]     load_val, ncs_cur;
  logic [STEP_BITS-1:0] t_val;
  logic                 t_hit, active, bad, proc, inst, windowed;
  logic [SUM_W-1:0]     sum_new, sum_eval;
  logic                 hit, closed, inst_hit, win_hit, rep_after;
  logic                 tail, tail_hit, emit;
  logic [DT_W-1:0]      dtime;

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_mode   <= MODE_INST;
      cfg_r.start_step    <= CFG16_W'(1);
      cfg_r.sample_period <= CFG16_W'(1);
      cfg_r.lab_delay     <= '0;
      cfg_r.detect_limit  <= '0;
      cfg_r.sample_volume <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:   cfg_r.sample_mode   <= ssd_mode_t'(cfg_data[1:0]);
        REG_START:  cfg_r.start_step    <= cfg_data[CFG16_W-1:0];
        REG_PERIOD: cfg_r.sample_period <= cfg_data[CFG16_W-1:0];
        REG_DELAY:  cfg_r.lab_delay     <= cfg_data[CFG16_W-1:0];
        REG_LIMIT:  cfg_r.detect_limit  <= cfg_data[CONC_W-1:0];
        REG_VOLUME: cfg_r.sample_volume <= cfg_data[CFG16_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the held sample is evaluated whenever the result slot is free.
  assign out_free = !out_v_r || !out_stall;
  assign fire     = item_v_r && out_free;
  assign in_stall = item_v_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (!in_stall) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  // Effective start and period, and the first check step of a series.
  assign start_eff  = eff_nonzero(cfg_r.start_step);
  assign period_eff = eff_nonzero(cfg_r.sample_period);
  assign inst       = (cfg_r.sample_mode == MODE_INST);
  assign windowed   = (cfg_r.sample_mode == MODE_COMP) || (cfg_r.sample_mode == MODE_FILT);

  always_comb begin
    if (inst) begin
      load_val = NCS_W'(start_eff);
    end else if (start_eff > CFG16_W'(1)) begin
      load_val = NCS_W'(start_eff - CFG16_W'(1));
    end else begin
      load_val = NCS_W'(period_eff);
    end
  end

  assign ncs_cur = (step_count_r == '0) ? load_val : ncs_r;

  // Step bookkeeping: a saturated counter stops counting, summing and testing.
  assign active  = !reported_r;
  assign bad     = active && (cfg_r.sample_mode == MODE_BAD);
  assign proc    = active && !bad && !(&step_count_r);
  assign t_val   = step_count_r + STEP_BITS'(1);
  assign t_hit   = (NCS_W'(t_val) == ncs_cur);

  // Window accumulation and threshold test.
  assign sum_new  = window_sum_r + SUM_W'(item_r.concentration);
  assign sum_eval = (proc && !inst) ? sum_new : window_sum_r;

  ssd_hit_cmp u_hit_cmp (
    .cfg (cfg_r),
    .sum (sum_eval),
    .hit (hit)
  );

  assign closed    = proc && !inst && t_hit;
  assign inst_hit  = proc && inst && t_hit && (item_r.concentration > cfg_r.detect_limit);
  assign win_hit   = closed && hit;
  assign rep_after = reported_r || bad || inst_hit || win_hit;

  // End of series without a result: test the open partial window.
  assign tail     = item_r.last_sample && !rep_after;
  assign tail_hit = tail && windowed && !closed && hit;
  assign emit     = bad || inst_hit || win_hit || tail;

  // Detection time; only the low bits are reported.
  always_comb begin
    priority if (inst_hit) begin
      dtime = DT_W'(t_val) - DT_W'(1) + DT_W'(cfg_r.lab_delay);
    end else if (win_hit) begin
      dtime = DT_W'(t_val) + DT_W'(cfg_r.lab_delay);
    end else if (tail_hit) begin
      dtime = DT_W'(ncs_cur) + DT_W'(cfg_r.lab_delay);
    end else begin
      dtime = '0;
    end
  end

  always_comb begin
    if (bad) begin
      out_nxt.status = STAT_BAD;
    end else if (inst_hit || win_hit || tail_hit) begin
      out_nxt.status = STAT_HIT;
    end else begin
      out_nxt.status = STAT_NONE;
    end
    out_nxt.detect_time = dtime[TIME_W-1:0];
  end

  // Next series state; the last sample clears everything.
  always_comb begin
    if (item_r.last_sample) begin
      step_count_nxt = '0;
      window_sum_nxt = '0;
      ncs_nxt        = '0;
      reported_nxt   = 1'b0;
    end else begin
      step_count_nxt = proc ? t_val : step_count_r;
      if (proc && !inst) begin
        window_sum_nxt = closed ? '0 : sum_new;
      end else begin
        window_sum_nxt = window_sum_r;
      end
      ncs_nxt      = (proc && t_hit) ? (ncs_cur + NCS_W'(period_eff)) : ncs_cur;
      reported_nxt = rep_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= '0;
      window_sum_r <= '0;
      ncs_r        <= '0;
      reported_r   <= 1'b0;
    end else if (fire) begin
      step_count_r <= step_count_nxt;
      window_sum_r <= window_sum_nxt;
      ncs_r        <= ncs_nxt;
      reported_r   <= reported_nxt;
    end
  end

  // Result register: loaded on an emitting step, held while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && emit) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Every series that has not reported yet reports on its last sample.
  a_series_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_r.last_sample && !reported_r |=> out_valid)
    else $error("series ended without a result");

  // The last sample leaves the series state cleared.
  a_series_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_r.last_sample |=> (step_count_r == '0) && !reported_r
                                   && (window_sum_r == '0))
    else $error("series state not cleared after last sample");

  // Detection time is zero unless the status is a detection.
  a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_HIT) |-> (out_data.detect_time == '0))
    else $error("detect_time set without detection");

  // The input side only stalls behind a held sample and a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_v_r && out_v_r && out_stall)
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the sampled sensor detection block.
// It predicts one report per series and checks every report on the result channel.
// Depends on rtl/ssd_pkg.sv and rtl/sampled_sensor_detection.sv.
`timescale 1ns / 1ps

module tb_top;
  import ssd_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ssd_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ssd_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [REGIDX_W-1:0] cfg_index;
  logic [CFGDAT_W-1:0] cfg_data;

  sampled_sensor_detection u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register values as the block holds them, starting from the reset defaults.
  ssd_cfg_t cur_cfg = '{sample_mode: MODE_INST, start_step: 16'd1, sample_period: 16'd1,
                        lab_delay: '0, detect_limit: '0, sample_volume: '0};

  // Predicted series state.
  logic [15:0]      ser_steps = '0;
  logic [SUM_W-1:0] ser_sum   = '0;
  logic [16:0]      ser_next  = '0;
  bit               ser_done  = 1'b0;

  // Reports predicted but not yet transferred, oldest first.
  ssd_out_t pending_reports[$];

  // Idling controls shared by the tests, the sender task and the report checker.
  bit          src_pause_en     = 1'b1;
  bit          sink_pause_en    = 1'b1;
  int unsigned sink_hold_cycles = 0;
  bit          sink_hold_tog    = 1'b0;
  bit          sink_hold        = 1'b0;

  int unsigned err_count = 0;
  int unsigned n_samples = 0;
  int unsigned n_series  = 0;
  int unsigned n_reports = 0;
  int unsigned n_loads   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A generous bound on the whole run.
  initial begin : watchdog
    #10_000_000;
    $display("Run timed out with %0d reports outstanding.", pending_reports.size());
    $display("TB_ERROR");
    $finish;
  end

  // Compare the window average against the limit without dividing.
  function automatic bit window_over_limit(input logic [SUM_W-1:0] sum,
                                           input logic [15:0] per);
    logic [63:0] scale;
    scale = (cur_cfg.sample_mode == MODE_FILT) ? 64'(cur_cfg.sample_volume)
                                                : 64'(SCALE_ONE);
    return (64'(sum) * scale) > (64'(cur_cfg.detect_limit) * 64'(per) * 64'd256);
  endfunction

  // Advance the series by one sample; returns 1 when the sample yields a report.
  function automatic bit predict_detection(input ssd_in_t s, output ssd_out_t rep);
    ssd_mode_t         mode;
    logic [15:0]       first;
    logic [15:0]       per;
    logic [16:0]       tnow;
    logic [1:0]        stat;
    logic [TIME_W-1:0] dt;
    bit                emit;
    bit                closed;
    mode   = cur_cfg.sample_mode;
    first  = (cur_cfg.start_step == '0) ? 16'd1 : cur_cfg.start_step;
    per    = (cur_cfg.sample_period == '0) ? 16'd1 : cur_cfg.sample_period;
    emit   = 1'b0;
    closed = 1'b0;
    stat   = STAT_NONE;
    dt     = '0;

    // The first step of a series loads the end of the first window or test point.
    if (ser_steps == '0) begin
      if (mode == MODE_INST) begin
        ser_next = 17'(first);
      end else if (first > 16'd1) begin
        ser_next = 17'(first) - 17'd1;
      end else begin
        ser_next = 17'(per);
      end
    end

    if (!ser_done) begin
      if (mode == MODE_BAD) begin
        emit     = 1'b1;
        stat     = STAT_BAD;
        ser_done = 1'b1;
      end else if (ser_steps != 16'hFFFF) begin
        tnow      = 17'(ser_steps) + 17'd1;
        ser_steps = ser_steps + 16'd1;
        if (mode == MODE_INST) begin
          if (tnow == ser_next) begin
            if (s.concentration > cur_cfg.detect_limit) begin
              emit     = 1'b1;
              stat     = STAT_HIT;
              dt       = 18'(tnow) - 18'd1 + 18'(cur_cfg.lab_delay);
              ser_done = 1'b1;
            end
            ser_next = ser_next + 17'(per);
          end
        end else begin
          ser_sum = ser_sum + SUM_W'(s.concentration);
          if (tnow == ser_next) begin
            closed = 1'b1;
            if (window_over_limit(ser_sum, per)) begin
              emit     = 1'b1;
              stat     = STAT_HIT;
              dt       = 18'(tnow) + 18'(cur_cfg.lab_delay);
              ser_done = 1'b1;
            end
            ser_sum  = '0;
            ser_next = ser_next + 17'(per);
          end
        end
      end
    end

    // The last sample closes an open window as a partial one, or reports no detection.
    if (s.last_sample && !ser_done) begin
      if ((mode == MODE_COMP || mode == MODE_FILT) && !closed &&
          window_over_limit(ser_sum, per)) begin
        stat = STAT_HIT;
        dt   = 18'(ser_next) + 18'(cur_cfg.lab_delay);
      end else begin
        stat = STAT_NONE;
        dt   = '0;
      end
      emit     = 1'b1;
      ser_done = 1'b1;
    end

    if (s.last_sample) begin
      ser_steps = '0;
      ser_sum   = '0;
      ser_next  = '0;
      ser_done  = 1'b0;
    end

    rep.status      = stat;
    rep.detect_time = (stat == STAT_HIT) ? dt : '0;
    return emit;
  endfunction

  // Offer one sample after a random gap and predict its report once it is transferred.
  task automatic send_sample(input logic [CONC_W-1:0] conc, input logic last);
    ssd_in_t     item;
    ssd_out_t    rep;
    int unsigned gap;
    item.concentration = conc;
    item.last_sample   = last;
    gap = src_pause_en ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_samples++;
    if (last) n_series++;
    if (predict_detection(item, rep)) pending_reports.push_back(rep);
  endtask

  // Stop offering samples until every report has arrived and the pipeline is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // Write all six registers back to back once the block is idle.
  task automatic load_config(input ssd_cfg_t c);
    logic [REGIDX_W-1:0] idx[6];
    logic [CFGDAT_W-1:0] val[6];
    int                  k;
    wait_idle();
    idx = '{REG_MODE, REG_START, REG_PERIOD, REG_DELAY, REG_LIMIT, REG_VOLUME};
    val = '{CFGDAT_W'(c.sample_mode), CFGDAT_W'(c.start_step), CFGDAT_W'(c.sample_period),
            CFGDAT_W'(c.lab_delay), CFGDAT_W'(c.detect_limit), CFGDAT_W'(c.sample_volume)};
    for (k = 0; k < 6; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_cfg = c;
    n_loads++;
  endtask

  // Concentrations cluster around the limit so that hits and misses both occur.
  function automatic logic [CONC_W-1:0] draw_conc();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom();
      default: return cur_cfg.detect_limit + CONC_W'($urandom_range(0, 8)) - CONC_W'(4);
    endcase
  endfunction

  function automatic ssd_cfg_t random_config();
    ssd_cfg_t    c;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 6) begin
      c.sample_mode = MODE_INST;
    end else if (pick < 12) begin
      c.sample_mode = MODE_COMP;
    end else if (pick < 18) begin
      c.sample_mode = MODE_FILT;
    end else begin
      c.sample_mode = MODE_BAD;
    end
    case ($urandom_range(0, 9))
      0:       c.start_step = 16'hFFFF;
      1:       c.start_step = 16'($urandom());
      default: c.start_step = 16'($urandom_range(0, 10));
    endcase
    case ($urandom_range(0, 11))
      0:       c.sample_period = 16'hFFFF;
      1:       c.sample_period = 16'($urandom());
      default: c.sample_period = 16'($urandom_range(0, 6));
    endcase
    c.lab_delay = ($urandom_range(0, 1) != 0) ? 16'($urandom()) : 16'($urandom_range(0, 20));
    case ($urandom_range(0, 7))
      0:       c.detect_limit = '0;
      1:       c.detect_limit = '1;
      default: c.detect_limit = $urandom();
    endcase
    case ($urandom_range(0, 7))
      0:       c.sample_volume = '0;
      1:       c.sample_volume = '1;
      2, 3:    c.sample_volume = 16'($urandom());
      default: c.sample_volume = 16'($urandom_range(128, 384));
    endcase
    return c;
  endfunction

  // Defaults after reset: a hit on the second step, after which samples are ignored.
  task automatic test_reset_defaults();
    send_sample(32'd0, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample('1, 1'b0);
    send_sample(32'd0, 1'b1);
  endtask

  // Instantaneous sampling with zero start and period, then the largest values.
  task automatic test_instantaneous_extremes();
    load_config('{sample_mode: MODE_INST, start_step: 16'd0, sample_period: 16'd0,
                  lab_delay: 16'hFFFF, detect_limit: 32'hFFFF_FFFF, sample_volume: 16'hFFFF});
    send_sample('1, 1'b0);
    send_sample(32'd0, 1'b1);
    load_config('{sample_mode: MODE_INST, start_step: 16'd3, sample_period: 16'd2,
                  lab_delay: 16'hFFFF, detect_limit: 32'hFFFF_FFFE, sample_volume: 16'd0});
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample(32'hFFFF_FFFE, 1'b0);
    send_sample(32'd0, 1'b0);
    send_sample('1, 1'b1);
  endtask

  // Composite windows: a full first window that misses, a partial last window, and a series
  // that ends before its first window is complete.
  task automatic test_composite_windows();
    load_config('{sample_mode: MODE_COMP, start_step: 16'd1, sample_period: 16'd2,
                  lab_delay: 16'd5, detect_limit: 32'd1, sample_volume: 16'd0});
    send_sample(32'd2, 1'b0);
    send_sample(32'd0, 1'b0);
    send_sample(32'd3, 1'b1);
    load_config('{sample_mode: MODE_COMP, start_step: 16'd4, sample_period: 16'd2,
                  lab_delay: 16'd5, detect_limit: 32'd1, sample_volume: 16'd0});
    send_sample('1, 1'b1);
  endtask

  // Filtered mode at half volume: equality does not hit, one LSB above does.
  task automatic test_filtered_volume();
    load_config('{sample_mode: MODE_FILT, start_step: 16'd2, sample_period: 16'd1,
                  lab_delay: 16'd0, detect_limit: 32'h0001_0000, sample_volume: 16'h0080});
    send_sample(32'h0002_0000, 1'b0);
    send_sample(32'h0002_0000, 1'b0);
    send_sample(32'h0002_0001, 1'b1);
  endtask

  // The invalid mode reports on the first sample of a series and nothing after it.
  task automatic test_invalid_mode();
    load_config('{sample_mode: MODE_BAD, start_step: 16'd2, sample_period: 16'd3,
                  lab_delay: 16'd9, detect_limit: 32'd0, sample_volume: 16'd256});
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b1);
    send_sample('1, 1'b1);
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so the
  // block fills and stalls its input; then the sender waits for all reports.
  task automatic test_backpressure();
    int unsigned len;
    int unsigned k;
    int unsigned sent;
    load_config('{sample_mode: MODE_COMP, start_step: 16'd1, sample_period: 16'd2,
                  lab_delay: 16'd7, detect_limit: 32'h0000_8000, sample_volume: 16'd0});
    src_pause_en     = 1'b0;
    sink_pause_en    = 1'b0;
    sink_hold_cycles = 400;
    sink_hold_tog    = ~sink_hold_tog;
    sent = 0;
    while (sent < 60) begin
      len = $urandom_range(1, 3);
      for (k = 1; k <= len; k++) send_sample(draw_conc(), k == len);
      sent += len;
    end
    wait_idle();
    src_pause_en  = 1'b1;
    sink_pause_en = 1'b1;
  endtask

  // Random settings per phase, each phase a run of series with random content.
  task automatic test_random_series();
    int unsigned phase;
    int unsigned phase_items;
    int unsigned len;
    int unsigned k;
    for (phase = 0; phase < 23; phase++) begin
      load_config(random_config());
      case ($urandom_range(0, 3))
        0:       begin src_pause_en = 1'b0; sink_pause_en = 1'b0; end
        1:       begin src_pause_en = 1'b1; sink_pause_en = 1'b0; end
        2:       begin src_pause_en = 1'b0; sink_pause_en = 1'b1; end
        default: begin src_pause_en = 1'b1; sink_pause_en = 1'b1; end
      endcase
      phase_items = 0;
      while (phase_items < 36) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (k = 1; k <= len; k++) send_sample(draw_conc(), k == len);
        phase_items += len;
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
    end
    src_pause_en  = 1'b1;
    sink_pause_en = 1'b1;
  endtask

  // Long receiver hold-off: a new request restarts the count of stalled cycles.
  initial begin : sink_hold_ctl
    int unsigned hold_left;
    bit          hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_tog != hold_seen) begin
        hold_seen = sink_hold_tog;
        hold_left = sink_hold_cycles;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      sink_hold <= (hold_left != 0);
    end
  end

  // Report checker: compares each transfer with the oldest prediction and drives
  // out_stall from random pauses and the long hold-off.
  initial begin : report_checker
    ssd_out_t    want;
    int unsigned pause_left;
    pause_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        n_reports++;
        if (pending_reports.size() == 0) begin
          $error("unexpected report: status %0d, detect_time %0d",
                 out_data.status, out_data.detect_time);
          err_count++;
        end else begin
          want = pending_reports.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            err_count++;
          end
          if (out_data.detect_time !== want.detect_time) begin
            $error("detect_time: expected %0d, got %0d",
                   want.detect_time, out_data.detect_time);
            err_count++;
          end
        end
        pause_left = sink_pause_en ? $urandom_range(0, 13) : 0;
      end else if (pause_left != 0) begin
        pause_left--;
      end
      out_stall <= (pause_left != 0) || sink_hold;
    end
  end

  // Test sequence.
  initial begin : run_tests
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_instantaneous_extremes();
    test_composite_windows();
    test_filtered_volume();
    test_invalid_mode();
    test_backpressure();
    test_random_series();

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d predicted reports never arrived", pending_reports.size());
      err_count++;
    end
    $display("Sent %0d samples in %0d series over %0d register loads; checked %0d reports.",
             n_samples, n_series, n_loads, n_reports);
    $display("Modes covered: instantaneous, composite, filtered and invalid, with long stalls.");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
